// File: src/tcp_rto_pkg.sv
package tcp_rto_pkg;

  // event kinds carried in the request tuser
  typedef enum logic [1:0] {
    FUNC_RTT_SAMPLE  = 2'd0,
    FUNC_DATA_TMO    = 2'd1,
    FUNC_SYN_TMO     = 2'd2,
    FUNC_CLR_BACKOFF = 2'd3
  } func_t;

  // configuration register indexes
  localparam logic [1:0] CFG_RTO_MIN   = 2'd0;
  localparam logic [1:0] CFG_SYN_RTO   = 2'd1;
  localparam logic [1:0] CFG_SYN_LIMIT = 2'd2;

  // configuration reset values
  localparam logic [39:0] RTO_MIN_RST   = 40'd200000000;
  localparam logic [39:0] SYN_RTO_RST   = 40'd1000000000;
  localparam logic [4:0]  SYN_LIMIT_RST = 5'd5;

  // fixed field widths
  localparam int unsigned CFG_W    = 40;
  localparam int unsigned RTO_W    = 48;
  localparam int unsigned TMO_W    = 64;
  localparam int unsigned BACKOFF_W = 6;

  // base rto ceiling for raising the backoff (60 s)
  localparam logic [47:0] RTO_CAP_NS = 48'd60000000000;
  localparam logic [47:0] RTO_MAX    = {48{1'b1}};
  localparam logic [5:0]  BACKOFF_MAX = 6'd63;

  // backoff increment that sticks at its top value
  function automatic logic [5:0] bump_sat(input logic [5:0] b);
    bump_sat = (b < BACKOFF_MAX) ? b + 6'd1 : b;
  endfunction

  // left shift that saturates to all ones when bits fall off the top
  function automatic logic [63:0] sat_shl(input logic [63:0] v, input logic [5:0] s);
    logic [63:0] shl;
    logic [63:0] back;
    shl  = v << s;
    back = shl >> s;
    sat_shl = (back != v) ? {64{1'b1}} : shl;
  endfunction

endpackage

// File: src/tcp_rto_estimator_backoff_top.sv
// tcp retransmission timer with rtt estimation and exponential backoff, one connection
// request channel: in_tvalid / in_tready, event kind in in_tuser, event fields in in_tdata
// result channel: out_tvalid / out_tready, one result for every request accepted
// configuration: cfg_we with cfg_index and cfg_wdata, to be written by the user only
// while the block is idle (the block does not enforce this); a request is taken into
// an input register, and one pass of logic then updates srtt, rttvar, base rto and
// backoff and loads the result register
// throughput: one request per cycle while out_tready holds, set by the state update loop
// (srtt, rttvar, base rto and backoff feed back into the next request's pass)
// when the receiver stalls, the result register holds and the input register fills;
// in_tready drops only while both are occupied and out_tready is low
// reset (rst_n low, synchronous) clears the estimator state and backoff, empties both
// registers and restores the configuration defaults (rto min 200 ms, syn rto 1 s,
// syn retry limit 5)
module tcp_rto_estimator_backoff_top
  import tcp_rto_pkg::*;
#(
  parameter int unsigned TIME_BITS = 40
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // fields from bit 0: rtt_sample, seg_seq, seg_len, snd_una, unacked_left, syn_sent, pad
  input  logic [((TIME_BITS+82+7)/8)*8-1:0] in_tdata,
  // fields from bit 0: func
  input  logic [1:0]            in_tuser,
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // fields from bit 0: rto_ns, next_timeout_ns, retransmit, rearm, give_up,
  // backoff_count, sample_used, pad
  output logic [127:0]          out_tdata,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int unsigned IN_W = ((TIME_BITS + 82 + 7) / 8) * 8;
  localparam int unsigned SUMW = ((TIME_BITS > RTO_W) ? TIME_BITS : RTO_W) + 1;
  localparam int unsigned SEQ_LO = TIME_BITS;
  localparam int unsigned LEN_LO = TIME_BITS + 32;
  localparam int unsigned UNA_LO = TIME_BITS + 48;
  localparam int unsigned UNACK_B = TIME_BITS + 80;
  localparam int unsigned SYN_B   = TIME_BITS + 81;

  // configuration registers
  logic [CFG_W-1:0] rto_min_r;
  logic [CFG_W-1:0] syn_rto_r;
  logic [4:0]       syn_limit_r;

  // estimator state
  logic [TIME_BITS-1:0] srtt_r, srtt_nxt;
  logic [TIME_BITS-1:0] rttvar_r, rttvar_nxt;
  logic [RTO_W-1:0]     base_rto_r, base_rto_nxt;
  logic [5:0]           backoff_r, backoff_nxt;

  // input register
  logic                 in_full_r;
  logic [IN_W-1:0]      in_data_r;
  logic [1:0]           in_user_r;

  // result register
  logic                 out_full_r;
  logic [RTO_W-1:0]     res_rto_r;
  logic [TMO_W-1:0]     res_tmo_r, res_tmo_nxt;
  logic                 res_retx_r, res_retx_nxt;
  logic                 res_rearm_r, res_rearm_nxt;
  logic                 res_quit_r, res_quit_nxt;
  logic [5:0]           res_backoff_r;
  logic                 res_used_r, res_used_nxt;

  // handshake
  logic in_fire;
  logic pass_fire;

  // unpacked fields of the held request
  logic [TIME_BITS-1:0] rtt;
  logic [31:0]          seg_seq;
  logic [15:0]          seg_len;
  logic [31:0]          snd_una;
  logic                 unacked_left;
  logic                 syn_sent;
  func_t                func;

  // estimator datapath
  logic [TIME_BITS-1:0] rtt_diff;
  logic [TIME_BITS+1:0] var_sum;
  logic [TIME_BITS+2:0] srtt_sum;
  logic [TIME_BITS-1:0] smp_srtt;
  logic [TIME_BITS-1:0] smp_var;
  logic [SUMW-1:0]      var_w;
  logic [SUMW-1:0]      rto_sum;
  logic [RTO_W-1:0]     rto_raw;
  logic [RTO_W-1:0]     smp_rto;

  // timeout datapath
  logic [31:0] seg_last;
  logic [31:0] una_dist;
  logic        data_retx;
  logic [5:0]  bo_step1;
  logic [5:0]  bo_step2;
  logic        syn_quit;

  assign pass_fire = in_full_r && (!out_full_r || out_tready);
  assign in_tready = !in_full_r || pass_fire;
  assign in_fire   = in_tvalid && in_tready;

  assign rtt          = in_data_r[TIME_BITS-1:0];
  assign seg_seq      = in_data_r[SEQ_LO+31:SEQ_LO];
  assign seg_len      = in_data_r[LEN_LO+15:LEN_LO];
  assign snd_una      = in_data_r[UNA_LO+31:UNA_LO];
  assign unacked_left = in_data_r[UNACK_B];
  assign syn_sent     = in_data_r[SYN_B];
  assign func         = func_t'(in_user_r);

  // rtt sample: first sample or rfc 6298 smoothing, exact floor
  always_comb begin
    rtt_diff = (srtt_r >= rtt) ? srtt_r - rtt : rtt - srtt_r;
    var_sum  = {1'b0, rttvar_r, 1'b0} + {2'b00, rttvar_r} + {2'b00, rtt_diff};
    srtt_sum = {srtt_r, 3'b000} - {3'b000, srtt_r} + {3'b000, rtt};
    if (srtt_r == '0) begin
      smp_srtt = rtt;
      smp_var  = rtt >> 1;
    end else begin
      smp_srtt = srtt_sum[TIME_BITS+2:3];
      smp_var  = var_sum[TIME_BITS+1:2];
    end
  end

  // base rto = srtt + 4 * rttvar, saturated to 48 bits, floored at rto min
  always_comb begin
    var_w   = SUMW'(smp_var);
    rto_sum = SUMW'(smp_srtt) + (var_w << 2);
    if (var_w > SUMW'(RTO_MAX >> 2)) begin
      rto_raw = RTO_MAX;
    end else if (rto_sum > SUMW'(RTO_MAX)) begin
      rto_raw = RTO_MAX;
    end else begin
      rto_raw = rto_sum[RTO_W-1:0];
    end
    smp_rto = (rto_raw < RTO_W'(rto_min_r)) ? RTO_W'(rto_min_r) : rto_raw;
  end

  // data timeout: retransmit when snd_una has not passed the segment's last byte
  always_comb begin
    seg_last  = seg_seq + {16'd0, seg_len} - 32'd1;
    una_dist  = snd_una - seg_last;
    data_retx = (una_dist == 32'd0) || una_dist[31];
    bo_step1  = (base_rto_r < RTO_CAP_NS) ? bump_sat(backoff_r) : backoff_r;
    bo_step2  = data_retx ? bump_sat(bo_step1) : bo_step1;
  end

  // syn timeout gives up once the retry budget is spent
  assign syn_quit = (syn_limit_r == 5'd0) ||
                    ({1'b0, backoff_r} + 7'd1 >= {2'b00, syn_limit_r});

  // next state and result for the held request
  always_comb begin
    srtt_nxt      = srtt_r;
    rttvar_nxt    = rttvar_r;
    base_rto_nxt  = base_rto_r;
    backoff_nxt   = backoff_r;
    res_tmo_nxt   = '0;
    res_retx_nxt  = 1'b0;
    res_rearm_nxt = 1'b0;
    res_quit_nxt  = 1'b0;
    res_used_nxt  = 1'b0;
    case (func)
      FUNC_RTT_SAMPLE: begin
        if (!rtt[TIME_BITS-1] && (backoff_r == 6'd0)) begin
          srtt_nxt     = smp_srtt;
          rttvar_nxt   = smp_var;
          base_rto_nxt = smp_rto;
          res_used_nxt = 1'b1;
        end
      end
      FUNC_DATA_TMO: begin
        backoff_nxt  = bo_step2;
        res_retx_nxt = data_retx;
        if (unacked_left) begin
          res_rearm_nxt = 1'b1;
          res_tmo_nxt   = sat_shl(TMO_W'(base_rto_r), bo_step2);
        end
      end
      FUNC_SYN_TMO: begin
        if (syn_sent) begin
          if (syn_quit) begin
            res_quit_nxt = 1'b1;
          end else begin
            backoff_nxt   = bump_sat(backoff_r);
            res_retx_nxt  = 1'b1;
            res_rearm_nxt = 1'b1;
            res_tmo_nxt   = sat_shl(TMO_W'(syn_rto_r), bump_sat(backoff_r));
          end
        end
      end
      FUNC_CLR_BACKOFF: begin
        backoff_nxt = 6'd0;
      end
      default: begin
        backoff_nxt = backoff_r;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rto_min_r   <= RTO_MIN_RST;
      syn_rto_r   <= SYN_RTO_RST;
      syn_limit_r <= SYN_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RTO_MIN:   rto_min_r   <= cfg_wdata;
        CFG_SYN_RTO:   syn_rto_r   <= cfg_wdata;
        CFG_SYN_LIMIT: syn_limit_r <= cfg_wdata[4:0];
        default: begin
          rto_min_r <= rto_min_r;
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_fire) begin
      in_full_r <= 1'b1;
    end else if (pass_fire) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_data_r <= in_tdata;
      in_user_r <= in_tuser;
    end
  end

  // estimator state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srtt_r     <= '0;
      rttvar_r   <= '0;
      base_rto_r <= '0;
      backoff_r  <= '0;
    end else if (pass_fire) begin
      srtt_r     <= srtt_nxt;
      rttvar_r   <= rttvar_nxt;
      base_rto_r <= base_rto_nxt;
      backoff_r  <= backoff_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_full_r <= 1'b0;
    end else if (pass_fire) begin
      out_full_r <= 1'b1;
    end else if (out_tready) begin
      out_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pass_fire) begin
      res_rto_r     <= base_rto_nxt;
      res_tmo_r     <= res_tmo_nxt;
      res_retx_r    <= res_retx_nxt;
      res_rearm_r   <= res_rearm_nxt;
      res_quit_r    <= res_quit_nxt;
      res_backoff_r <= backoff_nxt;
      res_used_r    <= res_used_nxt;
    end
  end

  assign out_tvalid = out_full_r;
  assign out_tdata  = {6'd0, res_used_r, res_backoff_r, res_quit_r, res_rearm_r,
                       res_retx_r, res_tmo_r, res_rto_r};

`ifndef NO_ASSERTIONS
  // a result that gives up never asks for a resend or a restart
  a_quit_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_full_r && res_quit_r |-> !res_retx_r && !res_rearm_r)
    else $error("give_up together with retransmit or rearm");

  // timeout is zero whenever the timer is not re-armed
  a_tmo_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_full_r && !res_rearm_r |-> res_tmo_r == '0)
    else $error("non-zero timeout without rearm");

  // karn's rule: a used sample implies no backoff
  a_karn: assert property (@(posedge clk) disable iff (!rst_n)
    out_full_r && res_used_r |-> res_backoff_r == 6'd0)
    else $error("sample used while backed off");

  // the request side only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_full_r && in_full_r && !out_tready)
    else $error("request stalled without a blocked result");

  // result register reflects the state it just wrote
  a_res_state: assert property (@(posedge clk) disable iff (!rst_n)
    pass_fire |=> res_backoff_r == backoff_r && res_rto_r == base_rto_r)
    else $error("result does not match updated state");
`endif

endmodule

// File: verif/tb_tcp_rto_estimator_backoff_top.sv
`timescale 1ns / 100ps

module tb_tcp_rto_estimator_backoff_top;
  import tcp_rto_pkg::*;

  localparam int TIME_BITS   = 40;
  localparam int IN_W        = ((TIME_BITS + 82 + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PHASE = 270;
  localparam int N_PHASES    = 6;
  localparam logic [63:0] TMO_ALL_ONES = {64{1'b1}};
  localparam logic [63:0] RTO_CEIL     = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] BACKOFF_CAP  = 64'd60_000_000_000;

  // one timer event as offered on the request channel
  typedef struct {
    func_t       func;
    logic [39:0] rtt;
    logic [31:0] seq;
    logic [15:0] len;
    logic [31:0] una;
    logic        unacked;
    logic        syn;
  } tmr_event_t;

  // one timer decision as returned on the result channel
  typedef struct {
    logic [47:0] rto;
    logic [63:0] tmo;
    logic        retx;
    logic        rearm;
    logic        quit;
    logic [5:0]  backoff;
    logic        used;
  } tmr_decision_t;

  logic clk;
  logic rst_n = 1'b0;

  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata  = '0;
  logic [1:0]      in_tuser  = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [127:0]    out_tdata;
  logic            cfg_we    = 1'b0;
  logic [1:0]      cfg_index = '0;
  logic [39:0]     cfg_wdata = '0;

  tcp_rto_estimator_backoff_top #(.TIME_BITS(TIME_BITS)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // estimator state and register copies for the prediction
  logic [63:0] est_srtt;
  logic [63:0] est_rttvar;
  logic [47:0] est_rto;
  int          est_backoff;
  logic [39:0] reg_rto_min;
  logic [39:0] reg_syn_rto;
  logic [4:0]  reg_syn_limit;

  tmr_event_t    event_pending_q[$];
  tmr_decision_t decision_due_q[$];
  tmr_event_t    drv_event;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_count = 0;
  int events_sent = 0;
  int results_seen = 0;
  int cnt_retx = 0;
  int cnt_quit = 0;
  int cnt_used = 0;
  int cnt_sat = 0;
  int cycle_count = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // saturating left shift of a timeout
  function automatic logic [63:0] tmo_shift(input logic [63:0] v, input int s);
    if (s == 0)
      return v;
    if (v > (TMO_ALL_ONES >> s))
      return TMO_ALL_ONES;
    return v << s;
  endfunction

  function automatic void backoff_step();
    if (est_backoff < 63)
      est_backoff++;
  endfunction

  // rfc 6298 style update of srtt, rttvar and base rto, rounded down
  function automatic void rtt_update(input logic [63:0] r);
    logic [63:0] diff;
    logic [63:0] sum;
    if (est_srtt == 0) begin
      est_srtt   = r;
      est_rttvar = r >> 1;
    end else begin
      diff       = (est_srtt >= r) ? est_srtt - r : r - est_srtt;
      est_rttvar = (3 * est_rttvar + diff) >> 2;
      est_srtt   = (7 * est_srtt + r) >> 3;
    end
    sum = est_srtt + (est_rttvar << 2);
    if (sum > RTO_CEIL)
      sum = RTO_CEIL;
    if (sum < {24'd0, reg_rto_min})
      sum = {24'd0, reg_rto_min};
    est_rto = sum[47:0];
  endfunction

  // timer behaviour for one event, advancing the predicted state
  function automatic tmr_decision_t timer_predict(input tmr_event_t ev);
    tmr_decision_t d;
    logic [31:0]   seg_end;
    logic [31:0]   gap;
    d = '{rto: '0, tmo: '0, retx: 1'b0, rearm: 1'b0, quit: 1'b0, backoff: '0, used: 1'b0};
    case (ev.func)
      FUNC_RTT_SAMPLE: begin
        // karn: no sample while backed off, and negative samples are dropped
        if (!ev.rtt[39] && est_backoff == 0) begin
          rtt_update({24'd0, ev.rtt});
          d.used = 1'b1;
        end
      end
      FUNC_DATA_TMO: begin
        seg_end = ev.seq + {16'd0, ev.len} - 32'd1;
        gap     = ev.una - seg_end;
        if ({16'd0, est_rto} < BACKOFF_CAP)
          backoff_step();
        if (gap == 32'd0 || gap[31]) begin
          d.retx = 1'b1;
          backoff_step();
        end
        if (ev.unacked) begin
          d.rearm = 1'b1;
          d.tmo   = tmo_shift({16'd0, est_rto}, est_backoff);
        end
      end
      FUNC_SYN_TMO: begin
        if (ev.syn) begin
          if (reg_syn_limit == 0 || est_backoff + 1 >= int'(reg_syn_limit)) begin
            d.quit = 1'b1;
          end else begin
            backoff_step();
            d.retx  = 1'b1;
            d.rearm = 1'b1;
            d.tmo   = tmo_shift({24'd0, reg_syn_rto}, est_backoff);
          end
        end
      end
      default: est_backoff = 0;
    endcase
    d.rto     = est_rto;
    d.backoff = est_backoff[5:0];
    return d;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (err_count < 40)
      $display("mismatch at result %0d, %s: got %0h, want %0h", results_seen, what, got,
               want);
    err_count++;
  endtask

  task automatic check_decision(input tmr_decision_t got);
    tmr_decision_t want;
    if (decision_due_q.size() == 0) begin
      report_mismatch("result with no request outstanding", 64'd0, 64'd0);
    end else begin
      want = decision_due_q.pop_front();
      if (got.rto !== want.rto)
        report_mismatch("rto_ns", 64'(got.rto), 64'(want.rto));
      if (got.tmo !== want.tmo)
        report_mismatch("next_timeout_ns", got.tmo, want.tmo);
      if (got.retx !== want.retx)
        report_mismatch("retransmit", 64'(got.retx), 64'(want.retx));
      if (got.rearm !== want.rearm)
        report_mismatch("rearm", 64'(got.rearm), 64'(want.rearm));
      if (got.quit !== want.quit)
        report_mismatch("give_up", 64'(got.quit), 64'(want.quit));
      if (got.backoff !== want.backoff)
        report_mismatch("backoff_count", 64'(got.backoff), 64'(want.backoff));
      if (got.used !== want.used)
        report_mismatch("sample_used", 64'(got.used), 64'(want.used));
      cnt_retx += int'(want.retx);
      cnt_quit += int'(want.quit);
      cnt_used += int'(want.used);
      if (want.tmo == TMO_ALL_ONES)
        cnt_sat++;
    end
    results_seen++;
  endtask

  // request driver
  always @(posedge clk) begin : drv_proc
    logic nxt_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      nxt_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        decision_due_q.push_back(timer_predict(drv_event));
        events_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && event_pending_q.size() > 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        drv_event = event_pending_q.pop_front();
        in_tdata  <= IN_W'({drv_event.syn, drv_event.unacked, drv_event.una, drv_event.len,
                            drv_event.seq, drv_event.rtt});
        in_tuser  <= drv_event.func;
        nxt_valid = 1'b1;
      end
      in_tvalid <= nxt_valid;
    end
  end

  // result monitor
  always @(posedge clk) begin : mon_proc
    tmr_decision_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.rto     = out_tdata[47:0];
        got.tmo     = out_tdata[111:48];
        got.retx    = out_tdata[112];
        got.rearm   = out_tdata[113];
        got.quit    = out_tdata[114];
        got.backoff = out_tdata[120:115];
        got.used    = out_tdata[121];
        check_decision(got);
      end
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timed out with %0d results outstanding", decision_due_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic tmr_event_t mk_event(input func_t f, input logic [39:0] rtt,
                                          input logic [31:0] seq, input logic [15:0] len,
                                          input logic [31:0] una, input logic unacked,
                                          input logic syn);
    tmr_event_t ev;
    ev.func = f;
    ev.rtt = rtt;
    ev.seq = seq;
    ev.len = len;
    ev.una = una;
    ev.unacked = unacked;
    ev.syn = syn;
    return ev;
  endfunction

  function automatic logic [39:0] rand_rtt();
    case ($urandom_range(0, 9))
      0:       return 40'd0;
      1:       return {1'b1, 7'($urandom), 32'($urandom)};
      2:       return {1'b0, 7'($urandom), 32'($urandom)};
      3:       return 40'(64'($urandom_range(40, 90)) * 64'd1_000_000_000);
      4:       return 40'($urandom_range(1, 1000));
      default: return 40'($urandom_range(1000, 400_000_000));
    endcase
  endfunction

  // data timeout with the ack point close to the segment end, so both outcomes occur
  function automatic tmr_event_t rand_data_tmo();
    logic [31:0] seq;
    logic [15:0] len;
    logic [31:0] una;
    seq = $urandom;
    len = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1460));
    if ($urandom_range(0, 4) == 0)
      una = $urandom;
    else
      una = seq + {16'd0, len} - 32'd1 + 32'($urandom_range(0, 6)) - 32'd3;
    return mk_event(FUNC_DATA_TMO, rand_rtt(), seq, len, una, 1'($urandom), 1'($urandom));
  endfunction

  function automatic tmr_event_t rand_noise();
    return mk_event(func_t'($urandom_range(0, 3)), {8'($urandom), 32'($urandom)}, $urandom,
                    16'($urandom), $urandom, 1'($urandom), 1'($urandom));
  endfunction

  // edge values, every event kind and the corner cases of the timer
  task automatic load_directed();
    // syn timeout outside syn-sent
    event_pending_q.push_back(mk_event(FUNC_SYN_TMO, 40'd0, 32'd0, 16'd0, 32'd0, 1'b1, 1'b0));
    // data timeout before any sample, zero base rto
    event_pending_q.push_back(mk_event(FUNC_DATA_TMO, 40'd0, 32'd100, 16'd10, 32'd0, 1'b1,
                                       1'b0));
    // sample ignored while backed off
    event_pending_q.push_back(mk_event(FUNC_RTT_SAMPLE, 40'd5000, '0, '0, '0, 1'b0, 1'b0));
    event_pending_q.push_back(mk_event(FUNC_CLR_BACKOFF, '0, '0, '0, '0, 1'b0, 1'b0));
    // zero sample keeps srtt empty
    event_pending_q.push_back(mk_event(FUNC_RTT_SAMPLE, 40'd0, '0, '0, '0, 1'b0, 1'b0));
    // most negative sample
    event_pending_q.push_back(mk_event(FUNC_RTT_SAMPLE, 40'h80_0000_0000, '0, '0, '0, 1'b0,
                                       1'b0));
    // largest positive sample as the first one, then small ones
    event_pending_q.push_back(mk_event(FUNC_RTT_SAMPLE, 40'h7F_FFFF_FFFF, '0, '0, '0, 1'b0,
                                       1'b0));
    event_pending_q.push_back(mk_event(FUNC_RTT_SAMPLE, 40'd1, '0, '0, '0, 1'b0, 1'b0));
    event_pending_q.push_back(mk_event(FUNC_RTT_SAMPLE, 40'd100_000_000, '0, '0, '0, 1'b0,
                                       1'b0));
    // zero length segment, ack exactly at the wrapped end
    event_pending_q.push_back(mk_event(FUNC_DATA_TMO, '0, 32'd0, 16'd0, 32'hFFFF_FFFF, 1'b1,
                                       1'b0));
    // ack just past the end, no retransmission, not re-armed
    event_pending_q.push_back(mk_event(FUNC_DATA_TMO, '0, 32'hFFFF_0000, 16'hFFFF,
                                       32'hFFFF_FFFF, 1'b0, 1'b0));
    // ack far behind the end
    event_pending_q.push_back(mk_event(FUNC_DATA_TMO, '0, 32'h10, 16'h100, 32'd1, 1'b1,
                                       1'b0));
    event_pending_q.push_back(mk_event(FUNC_CLR_BACKOFF, '0, '0, '0, '0, 1'b0, 1'b0));
    // syn retries up to give-up
    repeat (6)
      event_pending_q.push_back(mk_event(FUNC_SYN_TMO, '0, '0, '0, '0, 1'b0, 1'b1));
    // all ones in every field
    event_pending_q.push_back(mk_event(FUNC_DATA_TMO, '1, '1, '1, '1, 1'b1, 1'b1));
    event_pending_q.push_back(mk_event(FUNC_CLR_BACKOFF, '1, '1, '1, '1, 1'b1, 1'b1));
    event_pending_q.push_back(mk_event(FUNC_RTT_SAMPLE, '1, '1, '1, '1, 1'b1, 1'b1));
  endtask

  // well-formed connection episodes with random content, plus some noise
  task automatic load_random(input int n_events);
    int added;
    int sel;
    int k;
    added = 0;
    while (added < n_events) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        // ack clears the backoff, then a run of rtt samples
        event_pending_q.push_back(mk_event(FUNC_CLR_BACKOFF, rand_rtt(), $urandom, '0, '0,
                                           1'($urandom), 1'($urandom)));
        k = $urandom_range(1, 8);
        repeat (k)
          event_pending_q.push_back(mk_event(FUNC_RTT_SAMPLE, rand_rtt(), $urandom,
                                             16'($urandom), $urandom, 1'($urandom),
                                             1'($urandom)));
        added += k + 1;
      end else if (sel < 60) begin
        k = $urandom_range(1, 6);
        repeat (k)
          event_pending_q.push_back(rand_data_tmo());
        added += k;
      end else if (sel < 68) begin
        // long run of timeouts drives the backoff to its ceiling
        k = $urandom_range(20, 50);
        repeat (k)
          event_pending_q.push_back(rand_data_tmo());
        added += k;
      end else if (sel < 85) begin
        // connection attempt with syn retries
        event_pending_q.push_back(mk_event(FUNC_CLR_BACKOFF, '0, '0, '0, '0, 1'b0, 1'b1));
        k = $urandom_range(1, 12);
        repeat (k)
          event_pending_q.push_back(mk_event(FUNC_SYN_TMO, rand_rtt(), $urandom,
                                             16'($urandom), $urandom, 1'($urandom),
                                             ($urandom_range(0, 7) != 0)));
        added += k + 1;
      end else begin
        k = $urandom_range(1, 4);
        repeat (k)
          event_pending_q.push_back(rand_noise());
        added += k;
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [39:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_RTO_MIN:   reg_rto_min = val;
      CFG_SYN_RTO:   reg_syn_rto = val;
      CFG_SYN_LIMIT: reg_syn_limit = val[4:0];
      default:       ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every request is out and every result is back
  task automatic drain();
    while (event_pending_q.size() != 0 || in_tvalid || decision_due_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : main_seq
    int ph;
    est_srtt      = '0;
    est_rttvar    = '0;
    est_rto       = '0;
    est_backoff   = 0;
    reg_rto_min   = RTO_MIN_RST;
    reg_syn_rto   = SYN_RTO_RST;
    reg_syn_limit = SYN_LIMIT_RST;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (ph = 0; ph < N_PHASES; ph++) begin
      if (ph < 2) begin
        send_idle_pct  = 33;
        recv_stall_pct = 69;
      end else if (ph < 4) begin
        send_idle_pct  = 69;
        recv_stall_pct = 33;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      case (ph)
        1: begin
          write_reg(CFG_RTO_MIN, 40'd0);
          write_reg(CFG_SYN_RTO, 40'd1);
          write_reg(CFG_SYN_LIMIT, 40'd16);
        end
        2: begin
          write_reg(CFG_RTO_MIN, {40{1'b1}});
          write_reg(CFG_SYN_RTO, {40{1'b1}});
          write_reg(CFG_SYN_LIMIT, 40'd31);
        end
        3: begin
          write_reg(CFG_RTO_MIN, 40'd1_000_000);
          write_reg(CFG_SYN_RTO, 40'd3_000_000_000);
          write_reg(CFG_SYN_LIMIT, 40'd0);
          // index outside the register map must be ignored
          write_reg(2'd3, 40'hA5_5A5A_A5A5);
        end
        4: begin
          write_reg(CFG_RTO_MIN, 40'd0);
          write_reg(CFG_SYN_RTO, 40'd0);
          write_reg(CFG_SYN_LIMIT, 40'd1);
        end
        5: begin
          write_reg(CFG_RTO_MIN, 40'd200_000_000);
          write_reg(CFG_SYN_RTO, 40'd1_000_000_000);
          write_reg(CFG_SYN_LIMIT, 40'd2);
        end
        default: load_directed();
      endcase
      load_random(ITEMS_PHASE);
      drain();
    end

    repeat (8) @(posedge clk);
    if (decision_due_q.size() != 0)
      report_mismatch("results never returned", 64'(decision_due_q.size()), 64'd0);
    $display("run covered %0d timer events in %0d register settings, %0d results checked",
             events_sent, N_PHASES, results_seen);
    $display("retransmits %0d, syn give-ups %0d, samples taken %0d, saturated timeouts %0d",
             cnt_retx, cnt_quit, cnt_used, cnt_sat);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", err_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
